// ===== design/kac_pkg.sv =====
// shared types and constants of the key association cache
package kac_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int MAC_W  = 48;
  localparam int WORD_W = 64;
  localparam int KEY_W  = 256;
  localparam int SSID_W = 8;
  localparam int LIFE_W = 16;
  localparam int EL_W   = 8;
  localparam int REMOVED_W = 6;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_LIFETIME = 1'b0;
  localparam logic REG_DEFAULT  = 1'b1;
  localparam logic [LIFE_W-1:0] DEFAULT_LIFE_RST = 16'd43200;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SEEN   = 3'd1;
  localparam logic [2:0] OP_TICK   = 3'd2;
  localparam logic [2:0] OP_LOOKUP = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_IGNORED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REFRESHED = 3'd4;
  localparam logic [2:0] ST_DONE      = 3'd5;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [WORD_W-1:0] ident_hi;
    logic [WORD_W-1:0] ident_lo;
    logic [SSID_W-1:0] ssid;
    logic [LIFE_W-1:0] life;
  } meta_t;

  localparam int META_W = $bits(meta_t);

endpackage

// ===== design/kac_ram.sv =====
// simple dual port ram, one write and one registered read port
module kac_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/kac_cfg.sv =====
// apb configuration registers of the key association cache
module kac_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kac_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [kac_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [kac_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [kac_pkg::LIFE_W-1:0]       fresh_life
);

  logic [kac_pkg::LIFE_W-1:0] lifetime_setting;
  logic [kac_pkg::LIFE_W-1:0] default_lifetime;
  logic                       wr;
  logic                       idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime_setting <= '0;
      default_lifetime <= kac_pkg::DEFAULT_LIFE_RST;
    end else if (wr) begin
      unique case (idx)
        kac_pkg::REG_LIFETIME: lifetime_setting <= pwdata[kac_pkg::LIFE_W-1:0];
        kac_pkg::REG_DEFAULT:  default_lifetime <= pwdata[kac_pkg::LIFE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      kac_pkg::REG_LIFETIME:
        prdata = {{(kac_pkg::APB_DATA_W-kac_pkg::LIFE_W){1'b0}}, lifetime_setting};
      kac_pkg::REG_DEFAULT:
        prdata = {{(kac_pkg::APB_DATA_W-kac_pkg::LIFE_W){1'b0}}, default_lifetime};
      default: prdata = '0;
    endcase
  end

  // zero setting falls back to the default
  assign fresh_life = (lifetime_setting == '0) ? default_lifetime : lifetime_setting;

endmodule

// ===== design/key_association_cache.sv =====
// top level of the key association cache: control sequencer around entry memories
//
// usage
//   a request is taken at a rising edge with start high and busy low; the
//   op code and all payload fields are sampled at that edge
//   each request gives one result, shown for one cycle with done high;
//   the receiver cannot stall, so nothing waits on it
//   add and seen: done after a sweep of all 32
//   entries through the meta memory read port, one entry a cycle, then a
//   decide step and, for a real insert, an insert step
//   tick and lookup: done at the end of the same one-entry-a-cycle sweep
//   clear, unknown op and tick with zero elapsed: done the cycle after accept
//   one request at a time: busy stays high until the result is driven
//   the apb port writes lifetime_setting (0x0) and default_lifetime (0x4); the user
//   writes them only while no request is in flight, the block does not enforce it; pready is always high
//   reset empties the cache at once (valid bits in flops), no clearing pass;
//   default_lifetime returns to 43200 and lifetime_setting to zero
module key_association_cache (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        op,
  input  logic [kac_pkg::MAC_W-1:0]         peer_mac,
  input  logic [kac_pkg::WORD_W-1:0]        ident_hi,
  input  logic [kac_pkg::WORD_W-1:0]        ident_lo,
  input  logic [kac_pkg::WORD_W-1:0]        key_in_w0,
  input  logic [kac_pkg::WORD_W-1:0]        key_in_w1,
  input  logic [kac_pkg::WORD_W-1:0]        key_in_w2,
  input  logic [kac_pkg::WORD_W-1:0]        key_in_w3,
  input  logic                              key_present,
  input  logic [kac_pkg::SSID_W-1:0]        ssid_tag,
  input  logic [kac_pkg::EL_W-1:0]          elapsed,
  // result channel
  output logic                              done,
  output logic [2:0]                        status,
  output logic [kac_pkg::WORD_W-1:0]        key_out_w0,
  output logic [kac_pkg::WORD_W-1:0]        key_out_w1,
  output logic [kac_pkg::WORD_W-1:0]        key_out_w2,
  output logic [kac_pkg::WORD_W-1:0]        key_out_w3,
  output logic                              evicted,
  output logic [kac_pkg::REMOVED_W-1:0]     removed_count,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kac_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [kac_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [kac_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DECIDE, S_INSERT} state_t;

  state_t state;

  logic [kac_pkg::LIFE_W-1:0] fresh_life;

  // sampled request
  logic [2:0]                  op_q;
  logic [kac_pkg::MAC_W-1:0]   mac_q;
  logic [kac_pkg::WORD_W-1:0]  hi_q;
  logic [kac_pkg::WORD_W-1:0]  lo_q;
  logic [kac_pkg::KEY_W-1:0]   key_q;
  logic                        kp_q;
  logic [kac_pkg::SSID_W-1:0]  ssid_q;
  logic [kac_pkg::EL_W-1:0]    el_q;

  // per entry control state in flops
  logic [kac_pkg::DEPTH-1:0]   valid;
  logic [kac_pkg::IDX_W-1:0]   rank [kac_pkg::DEPTH];
  logic [kac_pkg::CNT_W-1:0]   count;

  // sweep pipeline
  logic [kac_pkg::IDX_W:0]     icnt;
  logic                        p_vld;
  logic [kac_pkg::IDX_W-1:0]   p_idx;

  // sweep findings
  logic                        id_hit;
  logic                        peer_hit;
  logic                        peer_ssid_ok;
  logic [kac_pkg::IDX_W-1:0]   peer_idx;
  logic [kac_pkg::IDX_W-1:0]   peer_rank;
  kac_pkg::meta_t              peer_word;
  logic                        vic_have;
  logic [kac_pkg::IDX_W-1:0]   vic_idx;
  logic [kac_pkg::IDX_W-1:0]   vic_rank;
  logic [kac_pkg::LIFE_W-1:0]  vic_life;
  logic                        found;
  logic [kac_pkg::KEY_W-1:0]   found_key;
  logic [kac_pkg::CNT_W-1:0]   removed;
  logic                        evict_q;

  // memory ports
  kac_pkg::meta_t              mrd;
  kac_pkg::meta_t              mwd;
  logic [kac_pkg::KEY_W-1:0]   krd;
  logic                        m_we;
  logic [kac_pkg::IDX_W-1:0]   m_waddr;
  logic [kac_pkg::IDX_W-1:0]   raddr;

  // decoded control
  logic                        accept;
  logic                        v_p;
  logic [kac_pkg::IDX_W-1:0]   rank_p;
  logic                        sweep_hit;
  logic                        last;
  logic                        tick_drop;
  logic                        tick_upd;
  logic                        refresh;
  logic                        add_path;
  logic                        add_ok;
  logic                        full;
  logic                        dec_drop;
  logic                        drop_en;
  logic [kac_pkg::IDX_W-1:0]   drop_idx;
  logic [kac_pkg::IDX_W-1:0]   drop_rank;
  logic                        ins_en;
  logic                        clr_en;
  logic [kac_pkg::IDX_W-1:0]   free_idx;
  logic                        imm;

  kac_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fresh_life (fresh_life)
  );

  kac_ram #(.W(kac_pkg::META_W), .D(kac_pkg::DEPTH)) u_meta (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (mwd),
    .raddr (raddr),
    .rdata (mrd)
  );

  kac_ram #(.W(kac_pkg::KEY_W), .D(kac_pkg::DEPTH)) u_key (
    .clk   (clk),
    .we    (ins_en),
    .waddr (free_idx),
    .wdata (key_q),
    .raddr (raddr),
    .rdata (krd)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign raddr  = icnt[kac_pkg::IDX_W-1:0];

  assign v_p    = valid[p_idx];
  assign rank_p = rank[p_idx];
  assign sweep_hit = (state == S_SWEEP) && p_vld && v_p;
  assign last   = p_vld && (p_idx == kac_pkg::IDX_W'(kac_pkg::DEPTH - 1));

  // tick: drop what has run out, age the rest
  assign tick_drop = sweep_hit && (op_q == kac_pkg::OP_TICK)
                     && (mrd.life <= {{(kac_pkg::LIFE_W-kac_pkg::EL_W){1'b0}}, el_q});
  assign tick_upd  = sweep_hit && (op_q == kac_pkg::OP_TICK) && !tick_drop;

  // seen on a matching peer and ssid only refreshes the lifetime
  assign refresh  = (state == S_DECIDE) && (op_q == kac_pkg::OP_SEEN)
                    && peer_hit && peer_ssid_ok;
  assign add_path = !((op_q == kac_pkg::OP_SEEN) && peer_hit && peer_ssid_ok);
  assign add_ok   = kp_q && !id_hit;
  assign full     = (count == kac_pkg::CNT_W'(kac_pkg::DEPTH));
  // a stale entry for the same peer goes first; eviction only when still full
  assign dec_drop = (state == S_DECIDE) && add_path && add_ok && (peer_hit || full);

  assign drop_en   = tick_drop || dec_drop;
  assign drop_idx  = tick_drop ? p_idx  : (peer_hit ? peer_idx  : vic_idx);
  assign drop_rank = tick_drop ? rank_p : (peer_hit ? peer_rank : vic_rank);
  assign ins_en    = (state == S_INSERT);
  assign clr_en    = accept && (op == kac_pkg::OP_CLEAR);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = kac_pkg::DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = kac_pkg::IDX_W'(i);
      end
    end
  end

  // meta memory write port
  always_comb begin
    m_we    = tick_upd || refresh || ins_en;
    m_waddr = p_idx;
    mwd     = mrd;
    if (tick_upd) begin
      mwd.life = mrd.life - {{(kac_pkg::LIFE_W-kac_pkg::EL_W){1'b0}}, el_q};
    end else if (refresh) begin
      m_waddr = peer_idx;
      mwd     = peer_word;
      mwd.life = fresh_life;
    end else if (ins_en) begin
      m_waddr      = free_idx;
      mwd.mac      = mac_q;
      mwd.ident_hi = hi_q;
      mwd.ident_lo = lo_q;
      mwd.ssid     = ssid_q;
      mwd.life     = fresh_life;
    end
  end

  // valid bits and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (clr_en) begin
      valid <= '0;
      count <= '0;
    end else if (drop_en) begin
      valid[drop_idx] <= 1'b0;
      count <= count - 1'b1;
    end else if (ins_en) begin
      valid[free_idx] <= 1'b1;
      count <= count + 1'b1;
    end
  end

  // recency ranks, 0 is newest; kept dense over the valid entries
  always_ff @(posedge clk) begin
    if (drop_en) begin
      for (int j = 0; j < kac_pkg::DEPTH; j++) begin
        if (valid[j] && (rank[j] > drop_rank)) begin
          rank[j] <= rank[j] - 1'b1;
        end
      end
    end else if (ins_en) begin
      for (int j = 0; j < kac_pkg::DEPTH; j++) begin
        if (valid[j]) begin
          rank[j] <= rank[j] + 1'b1;
        end
      end
      rank[free_idx] <= '0;
    end
  end

  // requests that finish without a sweep
  assign imm = (op != kac_pkg::OP_ADD) && (op != kac_pkg::OP_SEEN)
               && (op != kac_pkg::OP_LOOKUP)
               && !((op == kac_pkg::OP_TICK) && (elapsed != '0));

  // sequencer with registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      p_vld <= 1'b0;
      icnt  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q   <= op;
            mac_q  <= peer_mac;
            hi_q   <= ident_hi;
            lo_q   <= ident_lo;
            key_q  <= {key_in_w3, key_in_w2, key_in_w1, key_in_w0};
            kp_q   <= key_present;
            ssid_q <= ssid_tag;
            el_q   <= elapsed;
            id_hit       <= 1'b0;
            peer_hit     <= 1'b0;
            peer_ssid_ok <= 1'b0;
            vic_have     <= 1'b0;
            found        <= 1'b0;
            removed      <= '0;
            evict_q      <= 1'b0;
            icnt         <= '0;
            p_vld        <= 1'b0;
            if (imm) begin
              done          <= 1'b1;
              key_out_w0    <= '0;
              key_out_w1    <= '0;
              key_out_w2    <= '0;
              key_out_w3    <= '0;
              evicted       <= 1'b0;
              status        <= (op == kac_pkg::OP_CLEAR || op == kac_pkg::OP_TICK)
                               ? kac_pkg::ST_DONE : kac_pkg::ST_IGNORED;
              removed_count <= (op == kac_pkg::OP_CLEAR)
                               ? kac_pkg::REMOVED_W'(count) : '0;
            end else begin
              state <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          // issue one read a cycle, process each entry in the cycle after its read
          p_vld <= (icnt < (kac_pkg::IDX_W+1)'(kac_pkg::DEPTH));
          p_idx <= raddr;
          if (icnt < (kac_pkg::IDX_W+1)'(kac_pkg::DEPTH)) begin
            icnt <= icnt + 1'b1;
          end
          if (sweep_hit) begin
            if (mrd.ident_hi == hi_q && mrd.ident_lo == lo_q) begin
              id_hit    <= 1'b1;
              found     <= 1'b1;
              found_key <= krd;
            end
            if (mrd.mac == mac_q) begin
              peer_hit     <= 1'b1;
              peer_ssid_ok <= (mrd.ssid == ssid_q);
              peer_idx     <= p_idx;
              peer_rank    <= rank_p;
              peer_word    <= mrd;
            end
            // lowest lifetime, newest on ties
            if (!vic_have || (mrd.life < vic_life)
                || ((mrd.life == vic_life) && (rank_p < vic_rank))) begin
              vic_have <= 1'b1;
              vic_idx  <= p_idx;
              vic_rank <= rank_p;
              vic_life <= mrd.life;
            end
          end
          if (tick_drop) begin
            removed <= removed + 1'b1;
          end
          if (last) begin
            p_vld <= 1'b0;
            if (op_q == kac_pkg::OP_ADD || op_q == kac_pkg::OP_SEEN) begin
              state <= S_DECIDE;
            end else begin
              state   <= S_IDLE;
              done    <= 1'b1;
              evicted <= 1'b0;
              if (op_q == kac_pkg::OP_TICK) begin
                status        <= kac_pkg::ST_DONE;
                removed_count <= kac_pkg::REMOVED_W'(removed + (tick_drop ? 1'b1 : 1'b0));
                key_out_w0 <= '0;
                key_out_w1 <= '0;
                key_out_w2 <= '0;
                key_out_w3 <= '0;
              end else begin
                // lookup, with a hit possible on the last entry itself
                removed_count <= '0;
                if (sweep_hit && mrd.ident_hi == hi_q && mrd.ident_lo == lo_q) begin
                  status <= kac_pkg::ST_FOUND;
                  {key_out_w3, key_out_w2, key_out_w1, key_out_w0} <= krd;
                end else if (found) begin
                  status <= kac_pkg::ST_FOUND;
                  {key_out_w3, key_out_w2, key_out_w1, key_out_w0} <= found_key;
                end else begin
                  status <= kac_pkg::ST_NOT_FOUND;
                  key_out_w0 <= '0;
                  key_out_w1 <= '0;
                  key_out_w2 <= '0;
                  key_out_w3 <= '0;
                end
              end
            end
          end
        end
        S_DECIDE: begin
          key_out_w0 <= '0;
          key_out_w1 <= '0;
          key_out_w2 <= '0;
          key_out_w3 <= '0;
          if (refresh) begin
            state         <= S_IDLE;
            done          <= 1'b1;
            status        <= kac_pkg::ST_REFRESHED;
            evicted       <= 1'b0;
            removed_count <= '0;
          end else if (!add_ok) begin
            state         <= S_IDLE;
            done          <= 1'b1;
            status        <= kac_pkg::ST_IGNORED;
            evicted       <= 1'b0;
            removed_count <= '0;
          end else begin
            state <= S_INSERT;
            if (dec_drop) begin
              removed <= kac_pkg::CNT_W'(1);
              evict_q <= !peer_hit;
            end
          end
        end
        S_INSERT: begin
          state         <= S_IDLE;
          done          <= 1'b1;
          status        <= kac_pkg::ST_ADDED;
          evicted       <= evict_q;
          removed_count <= kac_pkg::REMOVED_W'(removed);
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result only follows a request in flight or one just taken
  a_done_after_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a request");

  // the sequencer is back in idle whenever a result is shown
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while still busy");

  // fill count never passes the cache depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= kac_pkg::CNT_W'(kac_pkg::DEPTH))
    else $error("fill count overflow");
`endif

endmodule
